// ----- rtl/sra_pkg.sv -----
// Shared types and constants for the strided range alias check.
// No dependencies; used by every other file of the block.
package sra_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam int WIDE_W     = 64;
    localparam int COUNT_W    = 33;
    localparam int MUL_W      = ADDR_WIDTH + 3;
    localparam int STEP_W     = $clog2(WIDE_W + 1);

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
        logic [WIDE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WIDE_W-1:0] quot;
        logic [WIDE_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_CHECK   = 16'h0002,
        ST_DLT_DIV = 16'h0004,
        ST_EU_DIV  = 16'h0008,
        ST_EU_MUL  = 16'h0010,
        ST_EU_UPD  = 16'h0020,
        ST_GD_DIV  = 16'h0040,
        ST_M_DIV   = 16'h0080,
        ST_LCM_MUL = 16'h0100,
        ST_Y_DIV   = 16'h0200,
        ST_P_MUL   = 16'h0400,
        ST_R_DIV   = 16'h0800,
        ST_OFF_MUL = 16'h1000,
        ST_CNT_CHK = 16'h2000,
        ST_CNT_DIV = 16'h4000,
        ST_FINISH  = 16'h8000
    } state_t;

endpackage

// ----- rtl/sra_req_if.sv -----
// Input channel carrying two strided ranges.
// Depends on sra_pkg for the address width.
interface sra_req_if;
    logic                          valid;
    logic                          ready;
    logic [sra_pkg::ADDR_WIDTH-1:0] first_low;
    logic [sra_pkg::ADDR_WIDTH-1:0] second_low;
    logic [sra_pkg::ADDR_WIDTH-1:0] first_high;
    logic [sra_pkg::ADDR_WIDTH-1:0] second_high;
    logic [sra_pkg::ADDR_WIDTH-1:0] first_stride;
    logic [sra_pkg::ADDR_WIDTH-1:0] second_stride;

    modport source (output valid, first_low, second_low, first_high, second_high,
                    first_stride, second_stride, input ready);
    modport sink (input valid, first_low, second_low, first_high, second_high,
                  first_stride, second_stride, output ready);
endinterface

// ----- rtl/sra_rsp_if.sv -----
// Output channel carrying the alias result.
// Depends on sra_pkg for the result widths.
interface sra_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sra_pkg::WIDE_W-1:0]    common_start;
    logic [sra_pkg::WIDE_W-1:0]    common_stride;
    logic [sra_pkg::COUNT_W-1:0]   common_count;

    modport source (output valid, common_start, common_stride, common_count,
                    input ready);
    modport sink (input valid, common_start, common_stride, common_count,
                  output ready);
endinterface

// ----- rtl/sra_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sra_pkg for the request and response structs.
module sra_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sra_pkg::div_req_t req,
    output sra_pkg::div_rsp_t rsp
);
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [sra_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [sra_pkg::WIDE_W-1:0]        quo_reg, quo_next;
    logic [sra_pkg::WIDE_W-1:0]        rem_reg, rem_next;
    logic [sra_pkg::WIDE_W-1:0]        dvs_reg, dvs_next;
    logic [sra_pkg::WIDE_W:0]          trial;
    logic                              ge;

    assign trial = {rem_reg, quo_reg[sra_pkg::WIDE_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[sra_pkg::WIDE_W-2:0], ge};
            rem_next  = ge ? (trial[sra_pkg::WIDE_W-1:0] - dvs_reg)
                           : trial[sra_pkg::WIDE_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == sra_pkg::STEP_W'(sra_pkg::WIDE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;
endmodule

// ----- rtl/strided_range_alias_check.sv -----
// Strided range alias check: top level with sequencer, one multiplier and a
// shared divider. Depends on sra_pkg, sra_req_if, sra_rsp_if and sra_div.
//
// Usage: req takes one transfer holding two strided ranges (low, inclusive
// high, stride). rsp returns one transfer per request: the first shared
// address, the common stride (lcm of strides) and the count of shared
// addresses; all three are zero when the ranges cannot alias.
// req.ready is high only while the sequencer is idle; one request at a time.
// Each division runs on the shared 64-bit divider. A request runs one
// division for the start delta, one division plus a multiply and an update
// step per extended Euclid iteration (up to 47 on 32-bit strides), and up
// to five further divisions and three multiplies; early exits are shorter.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next result holds in the sequencer
// until the output register frees.
// Reset clears the sequencer and the output valid; no result is pending.
module strided_range_alias_check (
    input logic        clk,
    input logic        rst_n,
    sra_req_if.sink    req,
    sra_rsp_if.source  rsp
);
    localparam int AW = sra_pkg::ADDR_WIDTH;
    localparam int WW = sra_pkg::WIDE_W;
    localparam int MW = sra_pkg::MUL_W;

    sra_pkg::state_t state_reg, state_next;
    logic issued_reg, issued_next;
    logic zero_reg, zero_next;
    logic out_valid_reg, out_valid_next;

    logic [AW-1:0] lo1_reg, lo1_next, lo2_reg, lo2_next;
    logic [AW-1:0] hi1_reg, hi1_next, hi2_reg, hi2_next;
    logic [AW-1:0] s1_reg, s1_next, s2_reg, s2_next;
    logic [WW-1:0] len_reg, len_next, delta_reg, delta_next;
    logic [WW-1:0] r0_reg, r0_next, r1_reg, r1_next, tr_reg, tr_next;
    logic signed [MW-1:0] v0_reg, v0_next, v1_reg, v1_next, q_reg, q_next;
    logic [WW-1:0] g_reg, g_next, dg_reg, dg_next, m_reg, m_next;
    logic [WW-1:0] lcm_reg, lcm_next, yr_reg, yr_next, rr_reg, rr_next;
    logic [WW-1:0] off_reg, off_next, cnt_reg, cnt_next;
    logic signed [2*MW-1:0] mul_reg;
    logic signed [MW-1:0] mul_a, mul_b;

    logic [WW-1:0] start_reg, start_next, stride_reg, stride_next;
    logic [sra_pkg::COUNT_W-1:0] count_reg, count_next;

    sra_pkg::div_req_t div_req;
    sra_pkg::div_rsp_t div_rsp;

    logic [AW-1:0] high_min;
    logic [WW-1:0] y_abs, prod;
    logic swap, div_state, accept;

    sra_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign accept   = req.valid && req.ready;
    assign swap     = req.second_low < req.first_low;
    assign high_min = (hi1_reg < hi2_reg) ? hi1_reg : hi2_reg;
    assign y_abs    = v0_reg[MW-1] ? WW'(-v0_reg) : WW'(v0_reg);
    assign prod     = mul_reg[WW-1:0];
    assign div_state = (state_reg == sra_pkg::ST_DLT_DIV) || (state_reg == sra_pkg::ST_GD_DIV)
                    || (state_reg == sra_pkg::ST_M_DIV) || (state_reg == sra_pkg::ST_Y_DIV)
                    || (state_reg == sra_pkg::ST_R_DIV) || (state_reg == sra_pkg::ST_CNT_DIV)
                    || ((state_reg == sra_pkg::ST_EU_DIV) && (r1_reg != '0));

    always_comb
    begin
        div_req.start    = div_state && !issued_reg;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            sra_pkg::ST_DLT_DIV:
            begin
                div_req.dividend = WW'(lo2_reg - lo1_reg);
                div_req.divisor  = WW'(s1_reg);
            end
            sra_pkg::ST_EU_DIV:
            begin
                div_req.dividend = r0_reg;
                div_req.divisor  = r1_reg;
            end
            sra_pkg::ST_GD_DIV:
            begin
                div_req.dividend = delta_reg;
                div_req.divisor  = g_reg;
            end
            sra_pkg::ST_M_DIV:
            begin
                div_req.dividend = WW'(s1_reg);
                div_req.divisor  = g_reg;
            end
            sra_pkg::ST_Y_DIV:
            begin
                div_req.dividend = y_abs;
                div_req.divisor  = m_reg;
            end
            sra_pkg::ST_R_DIV:
            begin
                div_req.dividend = prod;
                div_req.divisor  = m_reg;
            end
            sra_pkg::ST_CNT_DIV:
            begin
                div_req.dividend = len_reg - 1'b1 - off_reg;
                div_req.divisor  = lcm_reg;
            end
            default:
            begin
                div_req.dividend = '0;
                div_req.divisor  = '0;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            sra_pkg::ST_EU_MUL:
            begin
                mul_a = q_reg;
                mul_b = v1_reg;
            end
            sra_pkg::ST_LCM_MUL:
            begin
                mul_a = MW'(s2_reg);
                mul_b = m_reg[MW-1:0];
            end
            sra_pkg::ST_P_MUL:
            begin
                mul_a = yr_reg[MW-1:0];
                mul_b = dg_reg[MW-1:0];
            end
            sra_pkg::ST_OFF_MUL:
            begin
                mul_a = MW'(s2_reg);
                mul_b = rr_reg[MW-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        lo1_next = lo1_reg; lo2_next = lo2_reg; hi1_next = hi1_reg; hi2_next = hi2_reg;
        s1_next = s1_reg; s2_next = s2_reg; len_next = len_reg; delta_next = delta_reg;
        r0_next = r0_reg; r1_next = r1_reg; tr_next = tr_reg;
        v0_next = v0_reg; v1_next = v1_reg; q_next = q_reg;
        g_next = g_reg; dg_next = dg_reg; m_next = m_reg; lcm_next = lcm_reg;
        yr_next = yr_reg; rr_next = rr_reg; off_next = off_reg; cnt_next = cnt_reg;
        start_next = start_reg; stride_next = stride_reg; count_next = count_reg;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;
        if (div_req.start)
            issued_next = 1'b1;
        if (div_rsp.done)
            issued_next = 1'b0;

        unique case (state_reg)
            sra_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    zero_next = 1'b0;
                    lo1_next = swap ? req.second_low    : req.first_low;
                    lo2_next = swap ? req.first_low     : req.second_low;
                    hi1_next = swap ? req.second_high   : req.first_high;
                    hi2_next = swap ? req.first_high    : req.second_high;
                    s1_next  = swap ? req.second_stride : req.first_stride;
                    s2_next  = swap ? req.first_stride  : req.second_stride;
                    state_next = sra_pkg::ST_CHECK;
                end
            end
            sra_pkg::ST_CHECK:
            begin
                len_next = WW'(high_min - lo2_reg) + 1'b1;
                if (s1_reg == '0 || s2_reg == '0 || high_min < lo2_reg)
                begin
                    zero_next  = 1'b1;
                    state_next = sra_pkg::ST_FINISH;
                end
                else
                    state_next = sra_pkg::ST_DLT_DIV;
            end
            sra_pkg::ST_DLT_DIV:
            begin
                if (div_rsp.done)
                begin
                    delta_next = (div_rsp.rem == '0) ? '0 : (WW'(s1_reg) - div_rsp.rem);
                    r0_next = WW'(s1_reg);
                    r1_next = WW'(s2_reg);
                    v0_next = '0;
                    v1_next = MW'(1);
                    state_next = sra_pkg::ST_EU_DIV;
                end
            end
            sra_pkg::ST_EU_DIV:
            begin
                if (r1_reg == '0)
                begin
                    g_next     = r0_reg;
                    state_next = sra_pkg::ST_GD_DIV;
                end
                else if (div_rsp.done)
                begin
                    q_next     = div_rsp.quot[MW-1:0];
                    tr_next    = div_rsp.rem;
                    state_next = sra_pkg::ST_EU_MUL;
                end
            end
            sra_pkg::ST_EU_MUL:
                state_next = sra_pkg::ST_EU_UPD;
            sra_pkg::ST_EU_UPD:
            begin
                r0_next = r1_reg;
                r1_next = tr_reg;
                v0_next = v1_reg;
                v1_next = v0_reg - mul_reg[MW-1:0];
                state_next = sra_pkg::ST_EU_DIV;
            end
            sra_pkg::ST_GD_DIV:
            begin
                if (div_rsp.done)
                begin
                    dg_next = div_rsp.quot;
                    if (div_rsp.rem != '0)
                    begin
                        zero_next  = 1'b1;
                        state_next = sra_pkg::ST_FINISH;
                    end
                    else
                        state_next = sra_pkg::ST_M_DIV;
                end
            end
            sra_pkg::ST_M_DIV:
            begin
                if (div_rsp.done)
                begin
                    m_next     = div_rsp.quot;
                    state_next = sra_pkg::ST_LCM_MUL;
                end
            end
            sra_pkg::ST_LCM_MUL:
                state_next = sra_pkg::ST_Y_DIV;
            sra_pkg::ST_Y_DIV:
            begin
                if (!issued_reg)
                    lcm_next = prod;
                if (div_rsp.done)
                begin
                    yr_next = (v0_reg[MW-1] && div_rsp.rem != '0) ? (m_reg - div_rsp.rem)
                                                                  : div_rsp.rem;
                    state_next = sra_pkg::ST_P_MUL;
                end
            end
            sra_pkg::ST_P_MUL:
                state_next = sra_pkg::ST_R_DIV;
            sra_pkg::ST_R_DIV:
            begin
                if (div_rsp.done)
                begin
                    rr_next    = div_rsp.rem;
                    state_next = sra_pkg::ST_OFF_MUL;
                end
            end
            sra_pkg::ST_OFF_MUL:
                state_next = sra_pkg::ST_CNT_CHK;
            sra_pkg::ST_CNT_CHK:
            begin
                off_next = prod;
                if (prod >= len_reg)
                begin
                    zero_next  = 1'b1;
                    state_next = sra_pkg::ST_FINISH;
                end
                else
                    state_next = sra_pkg::ST_CNT_DIV;
            end
            sra_pkg::ST_CNT_DIV:
            begin
                if (div_rsp.done)
                begin
                    cnt_next   = div_rsp.quot + 1'b1;
                    state_next = sra_pkg::ST_FINISH;
                end
            end
            sra_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    start_next  = zero_reg ? '0 : (WW'(lo2_reg) + off_reg);
                    stride_next = zero_reg ? '0 : lcm_reg;
                    count_next  = zero_reg ? '0 : cnt_reg[sra_pkg::COUNT_W-1:0];
                    state_next  = sra_pkg::ST_IDLE;
                end
            end
            default:
                state_next = sra_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sra_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        lo1_reg <= lo1_next; lo2_reg <= lo2_next; hi1_reg <= hi1_next; hi2_reg <= hi2_next;
        s1_reg <= s1_next; s2_reg <= s2_next; len_reg <= len_next; delta_reg <= delta_next;
        r0_reg <= r0_next; r1_reg <= r1_next; tr_reg <= tr_next;
        v0_reg <= v0_next; v1_reg <= v1_next; q_reg <= q_next;
        g_reg <= g_next; dg_reg <= dg_next; m_reg <= m_next; lcm_reg <= lcm_next;
        yr_reg <= yr_next; rr_reg <= rr_next; off_reg <= off_next; cnt_reg <= cnt_next;
        start_reg <= start_next; stride_reg <= stride_next; count_reg <= count_next;
        mul_reg <= mul_a * mul_b;
    end

    assign req.ready         = (state_reg == sra_pkg::ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.common_start  = start_reg;
    assign rsp.common_stride = stride_reg;
    assign rsp.common_count  = count_reg;

    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !div_rsp.busy)
        else $error("request taken while divider busy");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sra_pkg::ST_FINISH))
        else $error("result loaded outside finish");

    a_count_has_stride: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.common_count != '0) |-> rsp.common_stride != '0)
        else $error("nonzero count with zero stride");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> $past(div_rsp.busy))
        else $error("divider done without busy");
endmodule

// ----- dv/tb_strided_range_alias_check.sv -----
// Self-checking testbench for strided_range_alias_check: directed table, then random ranges.
// Depends on sra_pkg, sra_req_if, sra_rsp_if and the block's RTL.
module tb_strided_range_alias_check;

    typedef logic [sra_pkg::ADDR_WIDTH-1:0] addr_t;

    typedef struct packed {
        addr_t lo1, lo2, hi1, hi2, s1, s2;
    } ranges_t;

    typedef struct packed {
        logic [sra_pkg::WIDE_W-1:0]  start;
        logic [sra_pkg::WIDE_W-1:0]  stride;
        logic [sra_pkg::COUNT_W-1:0] count;
    } alias_t;

    typedef struct packed {
        ranges_t ranges;
        logic    known;
        alias_t  answer;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    sra_req_if req ();
    sra_rsp_if rsp ();

    strided_range_alias_check dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always #5 clk = ~clk;

    alias_t alias_q[$];
    int     mismatches = 0;
    bit     calm = 1'b0;
    bit     hold_off = 1'b0;
    bit     feed_done = 1'b0;
    row_t   rows[$];

    function automatic alias_t predict_alias(ranges_t r);
        alias_t a;
        logic [63:0] lo1, lo2, hi1, hi2, s1, s2, high, len, dlt, g, m, lcm, off, cnt, rr;
        logic [63:0] x, y;
        longint r0, r1, v0, v1, q, tr, tv, yr;
        a = '0;
        lo1 = r.lo1; lo2 = r.lo2; hi1 = r.hi1; hi2 = r.hi2; s1 = r.s1; s2 = r.s2;
        if (lo2 < lo1)
        begin
            lo1 = r.lo2; lo2 = r.lo1; hi1 = r.hi2; hi2 = r.hi1; s1 = r.s2; s2 = r.s1;
        end
        if (s1 == 0 || s2 == 0)
            return a;
        high = (hi1 < hi2) ? hi1 : hi2;
        if (high < lo2)
            return a;
        len = high - lo2 + 1;
        dlt = (s1 - ((lo2 - lo1) % s1)) % s1;
        x = s1; y = s2;
        while (y != 0)
        begin
            rr = x % y; x = y; y = rr;
        end
        g = x;
        if (dlt % g != 0)
            return a;
        m = s1 / g;
        lcm = s2 * m;
        r0 = s1; r1 = s2; v0 = 0; v1 = 1;
        while (r1 != 0)
        begin
            q = r0 / r1; tr = r0 - q * r1; tv = v0 - q * v1;
            r0 = r1; r1 = tr; v0 = v1; v1 = tv;
        end
        yr = v0 % longint'(m);
        if (yr < 0)
            yr += longint'(m);
        rr = (64'(yr) * (dlt / g)) % m;
        off = s2 * rr;
        if (off >= len)
            return a;
        cnt = (len - 1 - off) / lcm + 1;
        a.start = lo2 + off;
        a.stride = lcm;
        a.count = cnt[sra_pkg::COUNT_W-1:0];
        return a;
    endfunction

    function automatic addr_t pick_addr();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return addr_t'($urandom_range(0, 300));
            3: return '1 - addr_t'($urandom_range(0, 300));
            default: return addr_t'($urandom);
        endcase
    endfunction

    function automatic addr_t pick_stride();
        case ($urandom_range(0, 5))
            0: return addr_t'($urandom_range(1, 16));
            1: return addr_t'($urandom_range(1, 1000));
            2: return '1 - addr_t'($urandom_range(0, 3));
            3: return addr_t'(1) << $urandom_range(0, sra_pkg::ADDR_WIDTH - 1);
            default: return addr_t'($urandom) | addr_t'(1);
        endcase
    endfunction

    function automatic ranges_t random_ranges();
        ranges_t r;
        addr_t base;
        if ($urandom_range(0, 3) != 0)
        begin
            base = addr_t'($urandom);
            r.lo1 = base + addr_t'($urandom_range(0, 5000));
            r.lo2 = base + addr_t'($urandom_range(0, 5000));
            r.hi1 = r.lo1 + addr_t'($urandom_range(0, 100000));
            r.hi2 = r.lo2 + addr_t'($urandom_range(0, 100000));
            r.s1 = addr_t'($urandom_range(1, 600));
            r.s2 = addr_t'($urandom_range(1, 600));
        end
        else
        begin
            r.lo1 = pick_addr(); r.lo2 = pick_addr();
            r.hi1 = pick_addr(); r.hi2 = pick_addr();
            r.s1 = pick_stride(); r.s2 = pick_stride();
            if ($urandom_range(0, 1))
                r.hi1 = '1;
            if ($urandom_range(0, 1))
                r.hi2 = '1;
        end
        return r;
    endfunction

    function automatic row_t make_row(addr_t l1, addr_t l2, addr_t h1, addr_t h2,
                                      addr_t t1, addr_t t2, bit k,
                                      logic [63:0] st, logic [63:0] sd, logic [32:0] c);
        row_t w;
        w.ranges = '{l1, l2, h1, h2, t1, t2};
        w.known = k;
        w.answer = '{st, sd, c};
        return w;
    endfunction

    initial
    begin
        addr_t f;
        f = '1;
        rows.push_back(make_row(0, 0, 0, 0, 1, 1, 1, 0, 1, 1));
        rows.push_back(make_row(0, 0, f, f, 1, 1, 1, 0, 1, 33'h1_0000_0000));
        rows.push_back(make_row(f, f, f, f, f, f, 1, 64'(f), 64'(f), 1));
        rows.push_back(make_row(0, 0, f, f, f, f, 1, 0, 64'(f), 2));
        rows.push_back(make_row(0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, 0, 1, 0, 1, 0, 0, 0));
        rows.push_back(make_row(0, 100, 50, 200, 1, 1, 1, 0, 0, 0));
        rows.push_back(make_row(100, 0, 200, 50, 1, 1, 1, 0, 0, 0));
        rows.push_back(make_row(0, 1, 100, 100, 2, 2, 1, 0, 0, 0));
        rows.push_back(make_row(0, 0, 100, 100, 4, 6, 1, 0, 12, 9));
        rows.push_back(make_row(0, 5, 10, 10, 7, 11, 0, 0, 0, 0));
        rows.push_back(make_row(7, 3, 1000, 900, 6, 10, 0, 0, 0, 0));
        rows.push_back(make_row(3, 7, 900, 1000, 10, 6, 0, 0, 0, 0));
        rows.push_back(make_row(0, 0, f, f, f, f - 1, 0, 0, 0, 0));
        rows.push_back(make_row(1, f, f, f, f - 1, 1, 0, 0, 0, 0));
        rows.push_back(make_row(32'h5555_5555, 32'hAAAA_AAAA, f, f, 32'h8000_0000,
                                32'h0000_0003, 0, 0, 0, 0));
        rows.push_back(make_row(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, f,
                                32'h7FFF_FFFF, 32'h5555_5555, 0, 0, 0, 0));
        rows.push_back(make_row(0, 2, 1000, 1000, 12, 18, 0, 0, 0, 0));
        rows.push_back(make_row(10, 10, 12, 20, 9, 9, 0, 0, 0, 0));
    end

    initial
    begin
        ranges_t r;
        row_t    w;
        int      gap;
        req.valid <= 1'b0;
        req.first_low <= '0; req.second_low <= '0; req.first_high <= '0;
        req.second_high <= '0; req.first_stride <= '0; req.second_stride <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 140; i++)
        begin
            if (i < rows.size())
            begin
                w = rows[i];
                r = w.ranges;
                alias_q.push_back(w.known ? w.answer : predict_alias(r));
            end
            else
            begin
                r = random_ranges();
                alias_q.push_back(predict_alias(r));
            end
            if (i > 115)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                gap = $urandom_range(1, 17);
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else if (i == 0)
                @(posedge clk);
            req.valid <= 1'b1;
            req.first_low <= r.lo1; req.second_low <= r.lo2;
            req.first_high <= r.hi1; req.second_high <= r.hi2;
            req.first_stride <= r.s1; req.second_stride <= r.s2;
            if (i == rows.size() + 10)
                hold_off = 1'b1;
            do
                @(posedge clk);
            while (!req.ready);
        end
        req.valid <= 1'b0;
        feed_done = 1'b1;
    end

    // receiver ready: random short stalls, and one long stall while requests keep coming
    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (20000) @(posedge clk);
                hold_off = 1'b0;
                rsp.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(posedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        alias_t got, want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.common_start, rsp.common_stride, rsp.common_count};
            if (alias_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: start %h stride %h count %h",
                             got.start, got.stride, got.count);
            end
            else
            begin
                want = alias_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%h/%h got %h/%h/%h",
                                 want.start, want.stride, want.count,
                                 got.start, got.stride, got.count);
                end
            end
        end
    end

    initial
    begin
        wait (feed_done);
        wait (alias_q.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("** strided_range_alias_check: PASSED **");
        else
            $display("** strided_range_alias_check: FAILED **");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("** strided_range_alias_check: FAILED **");
        $finish;
    end
endmodule
